@@ hdl/lps_pkg.sv @@
// Shared types and constants for the LED pattern sequencer.
package lps_pkg;

  localparam int unsigned LED_W    = 10;
  localparam int unsigned RIGHT_W  = 14;
  localparam int unsigned HOLD_W   = 16;
  localparam int unsigned BTN_W    = 4;
  localparam int unsigned CFG_IDX_W = 3;

  // Mode codes
  localparam logic [BTN_W-1:0] MODE_CYLON   = 4'd2;
  localparam logic [BTN_W-1:0] MODE_COUNTER = 4'd4;
  localparam logic [BTN_W-1:0] MODE_SHUFFLE = 4'd8;

  // Register indexes
  localparam logic [CFG_IDX_W-1:0] REG_CYLON_HOLD        = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_COUNTER_HOLD      = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_SHUFFLE_HOLD      = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_SHUFFLE_FAST_HOLD = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_OFF_HOLD          = 3'd4;

  // Register reset values
  localparam logic [HOLD_W-1:0] CYLON_HOLD_RST        = 16'd75;
  localparam logic [HOLD_W-1:0] COUNTER_HOLD_RST      = 16'd15;
  localparam logic [HOLD_W-1:0] SHUFFLE_HOLD_RST      = 16'd100;
  localparam logic [HOLD_W-1:0] SHUFFLE_FAST_HOLD_RST = 16'd50;
  localparam logic [HOLD_W-1:0] OFF_HOLD_RST          = 16'd200;

  // Pattern constants
  localparam logic [LED_W-1:0]   CYLON_START  = 10'h003;
  localparam logic [LED_W-1:0]   CYLON_TOP    = 10'h300;
  localparam logic [LED_W-1:0]   COUNT_WRAP   = 10'h3FF;
  localparam logic [RIGHT_W-1:0] RIGHT_LIMIT  = 14'h015;
  localparam logic [LED_W-1:0]   LEFT_LIMIT   = 10'h2A0;
  localparam logic [LED_W-1:0]   FAST_FRAME   = 10'h0FC;

  typedef struct packed {
    logic [HOLD_W-1:0] cylon_hold;
    logic [HOLD_W-1:0] counter_hold;
    logic [HOLD_W-1:0] shuffle_hold;
    logic [HOLD_W-1:0] shuffle_fast_hold;
    logic [HOLD_W-1:0] off_hold;
  } hold_cfg_t;

  typedef struct packed {
    logic [BTN_W-1:0]   mode;
    logic               restart;
    logic               phase;
    logic [LED_W-1:0]   led_value;
    logic [LED_W-1:0]   left_bits;
    logic [RIGHT_W-1:0] right_bits;
  } seq_state_t;

  localparam seq_state_t SEQ_STATE_RST = '{
    mode:       '0,
    restart:    1'b1,
    phase:      1'b1,
    led_value:  '0,
    left_bits:  '0,
    right_bits: '0
  };

endpackage

@@ hdl/lps_cfg_regs.sv @@
// Hold-time configuration registers of the LED pattern sequencer.
module lps_cfg_regs (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           wr_en,
  input  logic [lps_pkg::CFG_IDX_W-1:0]  wr_index,
  input  logic [lps_pkg::HOLD_W-1:0]     wr_data,
  output lps_pkg::hold_cfg_t             cfg
);

  lps_pkg::hold_cfg_t cfg_r;
  lps_pkg::hold_cfg_t cfg_nxt;

  always_comb begin
    cfg_nxt = cfg_r;
    if (wr_en) begin
      case (wr_index)
        lps_pkg::REG_CYLON_HOLD:        cfg_nxt.cylon_hold        = wr_data;
        lps_pkg::REG_COUNTER_HOLD:      cfg_nxt.counter_hold      = wr_data;
        lps_pkg::REG_SHUFFLE_HOLD:      cfg_nxt.shuffle_hold      = wr_data;
        lps_pkg::REG_SHUFFLE_FAST_HOLD: cfg_nxt.shuffle_fast_hold = wr_data;
        lps_pkg::REG_OFF_HOLD:          cfg_nxt.off_hold          = wr_data;
        default:                        cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.cylon_hold        <= lps_pkg::CYLON_HOLD_RST;
      cfg_r.counter_hold      <= lps_pkg::COUNTER_HOLD_RST;
      cfg_r.shuffle_hold      <= lps_pkg::SHUFFLE_HOLD_RST;
      cfg_r.shuffle_fast_hold <= lps_pkg::SHUFFLE_FAST_HOLD_RST;
      cfg_r.off_hold          <= lps_pkg::OFF_HOLD_RST;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  assign cfg = cfg_r;

endmodule

@@ hdl/lps_step.sv @@
// Combinational pattern step: next sequencer state, LED bits and hold time.
module lps_step (
  input  logic [lps_pkg::BTN_W-1:0]  buttons,
  input  lps_pkg::seq_state_t        cur,
  input  lps_pkg::hold_cfg_t         cfg,
  output lps_pkg::seq_state_t        nxt,
  output logic [lps_pkg::LED_W-1:0]  leds,
  output logic [lps_pkg::HOLD_W-1:0] hold_ticks
);

  logic                         press;
  logic [lps_pkg::BTN_W-1:0]    mode_sel;
  logic                         restart_sel;
  logic [lps_pkg::LED_W-1:0]    lv;
  logic [lps_pkg::LED_W-1:0]    lv_step;
  logic                         ph;
  logic [lps_pkg::LED_W-1:0]    lb;
  logic [lps_pkg::RIGHT_W-1:0]  rb;
  logic [lps_pkg::LED_W-1:0]    lb_n;
  logic [lps_pkg::RIGHT_W-1:0]  rb_n;
  logic [lps_pkg::LED_W-1:0]    merged;

  always_comb begin
    press       = (buttons != '0) && ((buttons & cur.mode) == '0);
    mode_sel    = press ? buttons : cur.mode;
    restart_sel = press | cur.restart;

    nxt         = cur;
    nxt.mode    = mode_sel;
    nxt.restart = restart_sel;
    leds        = '0;
    hold_ticks  = cfg.off_hold;
    lv          = '0;
    lv_step     = '0;
    ph          = cur.phase;
    lb          = cur.left_bits;
    rb          = cur.right_bits;
    lb_n        = '0;
    rb_n        = '0;
    merged      = '0;

    case (mode_sel)
      lps_pkg::MODE_CYLON: begin
        lv          = restart_sel ? lps_pkg::CYLON_START : cur.led_value;
        ph          = restart_sel ? 1'b1 : cur.phase;
        nxt.restart = 1'b0;
        leds        = lv;
        if (ph) begin
          lv_step   = {lv[lps_pkg::LED_W-2:0], 1'b0};
          nxt.phase = (lv_step != lps_pkg::CYLON_TOP);
        end else begin
          lv_step   = {1'b0, lv[lps_pkg::LED_W-1:1]};
          nxt.phase = (lv_step == lps_pkg::CYLON_START);
        end
        nxt.led_value = lv_step;
        hold_ticks    = cfg.cylon_hold;
      end
      lps_pkg::MODE_COUNTER: begin
        lv            = restart_sel ? '0 : cur.led_value;
        nxt.restart   = 1'b0;
        leds          = lv;
        lv_step       = lv + lps_pkg::LED_W'(1);
        nxt.led_value = (lv_step == lps_pkg::COUNT_WRAP) ? '0 : lv_step;
        hold_ticks    = cfg.counter_hold;
      end
      lps_pkg::MODE_SHUFFLE: begin
        if (restart_sel) begin
          ph = 1'b1;
          lb = '0;
          rb = '0;
        end
        nxt.restart = 1'b0;
        nxt.phase   = ph;
        if ((rb < lps_pkg::RIGHT_LIMIT) && (lb < lps_pkg::LEFT_LIMIT)) begin
          // build inward from both ends with alternating bits
          rb_n       = {rb[lps_pkg::RIGHT_W-2:0], ph};
          lb_n       = {ph, lb[lps_pkg::LED_W-1:1]};
          nxt.phase  = ~ph;
          hold_ticks = cfg.shuffle_hold;
        end else if (lb > lps_pkg::LED_W'(1)) begin
          rb_n       = {rb[lps_pkg::RIGHT_W-2:0], 1'b0};
          lb_n       = {1'b0, lb[lps_pkg::LED_W-1:1]};
          hold_ticks = ((rb_n | lps_pkg::RIGHT_W'(lb_n)) == lps_pkg::RIGHT_W'(lps_pkg::FAST_FRAME))
                       ? cfg.shuffle_fast_hold : cfg.shuffle_hold;
        end else begin
          // pattern done: keep both parts and restart on the next step
          rb_n        = rb;
          lb_n        = lb;
          nxt.restart = 1'b1;
          hold_ticks  = cfg.shuffle_fast_hold;
        end
        merged         = lb_n | rb_n[lps_pkg::LED_W-1:0];
        nxt.left_bits  = lb_n;
        nxt.right_bits = rb_n;
        nxt.led_value  = merged;
        leds           = merged;
      end
      default: begin
        nxt.led_value = '0;
        leds          = '0;
        hold_ticks    = cfg.off_hold;
      end
    endcase
  end

endmodule

@@ hdl/led_pattern_sequencer.sv @@
// Top level of the LED pattern sequencer: input register, step logic, result register.
//
// Each input transfer is one pattern step carrying a 4-bit button code (0 = no press);
// each step yields exactly one result transfer with ten LED bits and a hold time in ticks.
// A press sharing no bit with the current mode becomes the new mode and restarts the
// pattern: mode 2 is a bouncing two-LED cylon, mode 4 a ten-bit up counter, mode 8 a
// shuffle, and any other code shows all LEDs off. Throughput is one step per clock: the
// step logic sits between a one-entry input register and the result register, and both
// advance together whenever the result register is empty or being taken. A result shows
// on out_valid once its step has moved from the input register into the result register,
// which waits while an earlier result is still not taken. The five hold registers are
// written through the cfg_ channel (index 0..4, other indexes dropped) and must only be
// changed while no step is in flight; cfg_ready is always high.
module led_pattern_sequencer (
  input  logic                           clk,
  input  logic                           rst_n,
  // step input
  input  logic                           in_valid,
  output logic                           in_ready,
  input  logic [lps_pkg::BTN_W-1:0]      in_buttons,
  // step result
  output logic                           out_valid,
  input  logic                           out_ready,
  output logic [lps_pkg::LED_W-1:0]      out_leds,
  output logic [lps_pkg::HOLD_W-1:0]     out_hold_ticks,
  // configuration writes
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [lps_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [lps_pkg::HOLD_W-1:0]     cfg_data
);

  lps_pkg::hold_cfg_t            cfg;
  lps_pkg::seq_state_t           state_r;
  lps_pkg::seq_state_t           state_nxt;

  logic                          in_vld_r;
  logic [lps_pkg::BTN_W-1:0]     in_btn_r;
  logic                          out_vld_r;
  logic [lps_pkg::LED_W-1:0]     leds_r;
  logic [lps_pkg::HOLD_W-1:0]    hold_r;
  logic [lps_pkg::LED_W-1:0]     leds_nxt;
  logic [lps_pkg::HOLD_W-1:0]    hold_nxt;
  logic                          advance;

  assign cfg_ready = 1'b1;

  lps_cfg_regs u_cfg (
    .clk      (clk),
    .rst_n    (rst_n),
    .wr_en    (cfg_valid & cfg_ready),
    .wr_index (cfg_index),
    .wr_data  (cfg_data),
    .cfg      (cfg)
  );

  // Advance the held step into the result register when there is room for it.
  assign advance  = in_vld_r & (~out_vld_r | out_ready);
  // Take a new step when the input register is empty or emptying this cycle.
  assign in_ready = ~in_vld_r | advance;

  lps_step u_step (
    .buttons    (in_btn_r),
    .cur        (state_r),
    .cfg        (cfg),
    .nxt        (state_nxt),
    .leds       (leds_nxt),
    .hold_ticks (hold_nxt)
  );

  // Input register: hold the button code until its step is worked.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r <= 1'b0;
    end else if (in_ready) begin
      in_vld_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      in_btn_r <= in_buttons;
    end
  end

  // Sequencer state moves on exactly once per worked step.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= lps_pkg::SEQ_STATE_RST;
    end else if (advance) begin
      state_r <= state_nxt;
    end
  end

  // Result register: drop valid once taken, reload on every advance.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (advance) begin
      out_vld_r <= 1'b1;
    end else if (out_ready) begin
      out_vld_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      leds_r <= leds_nxt;
      hold_r <= hold_nxt;
    end
  end

  assign out_valid      = out_vld_r;
  assign out_leds       = leds_r;
  assign out_hold_ticks = hold_r;

endmodule

@@ tb/lps_tb_pkg.sv @@
// Scoreboard class for the LED pattern sequencer testbench: step prediction and result checks.
`timescale 1ns / 1ps

package lps_tb_pkg;
  import lps_pkg::*;

  typedef struct packed {
    logic [LED_W-1:0]  leds;
    logic [HOLD_W-1:0] hold_ticks;
  } led_frame_t;

  class led_frame_checker;
    // hold registers as the block should see them
    logic [HOLD_W-1:0]  cylon_hold        = CYLON_HOLD_RST;
    logic [HOLD_W-1:0]  counter_hold      = COUNTER_HOLD_RST;
    logic [HOLD_W-1:0]  shuffle_hold      = SHUFFLE_HOLD_RST;
    logic [HOLD_W-1:0]  shuffle_fast_hold = SHUFFLE_FAST_HOLD_RST;
    logic [HOLD_W-1:0]  off_hold          = OFF_HOLD_RST;
    // pattern state
    logic [BTN_W-1:0]   mode       = '0;
    logic               restart    = 1'b1;
    logic               phase      = 1'b1;
    logic [LED_W-1:0]   led_value  = '0;
    logic [LED_W-1:0]   left_bits  = '0;
    logic [RIGHT_W-1:0] right_bits = '0;

    led_frame_t  frame_q[$];
    int unsigned failures = 0;

    function void write_hold(logic [CFG_IDX_W-1:0] idx, logic [HOLD_W-1:0] val);
      case (idx)
        REG_CYLON_HOLD:        cylon_hold        = val;
        REG_COUNTER_HOLD:      counter_hold      = val;
        REG_SHUFFLE_HOLD:      shuffle_hold      = val;
        REG_SHUFFLE_FAST_HOLD: shuffle_fast_hold = val;
        REG_OFF_HOLD:          off_hold          = val;
        default: ;
      endcase
    endfunction

    // Advance the pattern by one step and queue the frame it shows.
    function void note_step(logic [BTN_W-1:0] buttons);
      led_frame_t         frame;
      logic [RIGHT_W-1:0] merged;
      if (buttons != '0 && (buttons & mode) == '0) begin
        mode    = buttons;
        restart = 1'b1;
      end
      case (mode)
        MODE_CYLON: begin
          if (restart) begin
            led_value = CYLON_START;
            restart   = 1'b0;
            phase     = 1'b1;
          end
          frame.leds = led_value;
          if (phase) begin
            led_value = led_value << 1;
            if (led_value == CYLON_TOP) phase = 1'b0;
          end else begin
            led_value = led_value >> 1;
            if (led_value == CYLON_START) phase = 1'b1;
          end
          frame.hold_ticks = cylon_hold;
        end
        MODE_COUNTER: begin
          if (restart) begin
            restart   = 1'b0;
            led_value = '0;
          end
          frame.leds = led_value;
          led_value  = led_value + 1'b1;
          if (led_value == COUNT_WRAP) led_value = '0;
          frame.hold_ticks = counter_hold;
        end
        MODE_SHUFFLE: begin
          if (restart) begin
            restart    = 1'b0;
            led_value  = '0;
            phase      = 1'b1;
            left_bits  = '0;
            right_bits = '0;
          end
          if (right_bits < RIGHT_LIMIT && left_bits < LEFT_LIMIT) begin
            // build inward from both ends
            right_bits       = {right_bits[RIGHT_W-2:0], phase};
            left_bits        = {phase, left_bits[LED_W-1:1]};
            phase            = ~phase;
            frame.hold_ticks = shuffle_hold;
          end else if (left_bits > 10'd1) begin
            right_bits = right_bits << 1;
            left_bits  = left_bits >> 1;
            merged     = right_bits | RIGHT_W'(left_bits);
            frame.hold_ticks = (merged == RIGHT_W'(FAST_FRAME)) ? shuffle_fast_hold
                                                                : shuffle_hold;
          end else begin
            restart          = 1'b1;
            frame.hold_ticks = shuffle_fast_hold;
          end
          merged     = right_bits | RIGHT_W'(left_bits);
          led_value  = merged[LED_W-1:0];
          frame.leds = led_value;
        end
        default: begin
          led_value        = '0;
          frame.leds       = '0;
          frame.hold_ticks = off_hold;
        end
      endcase
      frame_q.push_back(frame);
    endfunction

    function int unsigned pending();
      return frame_q.size();
    endfunction

    function void check_frame(logic [LED_W-1:0] leds, logic [HOLD_W-1:0] hold_ticks);
      led_frame_t want;
      if (frame_q.size() == 0) begin
        failures++;
        $display("%0t: unexpected result: expected none, actual leds %h hold %0d",
                 $time, leds, hold_ticks);
        return;
      end
      want = frame_q.pop_front();
      if (leds !== want.leds) begin
        failures++;
        $display("%0t: leds mismatch: expected %h actual %h", $time, want.leds, leds);
      end
      if (hold_ticks !== want.hold_ticks) begin
        failures++;
        $display("%0t: hold_ticks mismatch: expected %0d actual %0d",
                 $time, want.hold_ticks, hold_ticks);
      end
    endfunction
  endclass

endpackage

@@ tb/led_pattern_sequencer_tb.sv @@
// Top-level testbench for the LED pattern sequencer: stimulus, handshakes and final verdict.
`timescale 1ns / 1ps

module led_pattern_sequencer_tb;
  import lps_pkg::*;
  import lps_tb_pkg::*;

  localparam int unsigned CYCLE_LIMIT   = 200000;
  localparam int unsigned SETTLE_CYCLES = 8;
  localparam logic [BTN_W-1:0]     BTN_NONE    = '0;
  // indexes past the last hold register; writes to them must be dropped
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_5 = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_6 = 3'd6;
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_7 = 3'd7;

  logic                 clk;
  logic                 rst_n      = 1'b0;
  logic                 in_valid   = 1'b0;
  logic                 in_ready;
  logic [BTN_W-1:0]     in_buttons = '0;
  logic                 out_valid;
  logic                 out_ready  = 1'b0;
  logic [LED_W-1:0]     out_leds;
  logic [HOLD_W-1:0]    out_hold_ticks;
  logic                 cfg_valid  = 1'b0;
  logic                 cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index  = '0;
  logic [HOLD_W-1:0]    cfg_data   = '0;

  led_frame_checker frame_chk = new;

  // idling controls, percent of cycles; quiet counters give stretches with no idling
  int unsigned send_idle_pct  = 0;
  int unsigned recv_stall_pct = 0;
  int unsigned send_quiet     = 0;
  int unsigned recv_quiet     = 0;
  int unsigned cycle_cnt      = 0;

  led_pattern_sequencer u_top (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_buttons     (in_buttons),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_leds       (out_leds),
    .out_hold_ticks (out_hold_ticks),
    .cfg_valid      (cfg_valid),
    .cfg_ready      (cfg_ready),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // Guard against a hung handshake: give up well past the slowest correct run.
  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt >= CYCLE_LIMIT) begin
      $display("FAILED: results differ");
      $finish;
    end
  end

  // Receiver: stall at random on the falling edge, with occasional quiet stretches.
  always @(negedge clk) begin
    if (recv_quiet > 0) begin
      recv_quiet--;
      out_ready <= 1'b1;
    end else begin
      if ($urandom_range(99) < 3) recv_quiet = $urandom_range(20, 60);
      out_ready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // Check every result transfer against the oldest predicted frame.
  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready)
      frame_chk.check_frame(out_leds, out_hold_ticks);
  end

  function automatic bit send_gap();
    if (send_quiet > 0) begin
      send_quiet--;
      return 1'b0;
    end
    if ($urandom_range(99) < 3) send_quiet = $urandom_range(20, 60);
    return ($urandom_range(99) < send_idle_pct);
  endfunction

  // Offer one step and hold it until the transfer; valid stays high afterwards
  // so back-to-back steps need no drop.
  task automatic send_step(input logic [BTN_W-1:0] buttons);
    while (send_gap()) begin
      in_valid = 1'b0;
      @(negedge clk);
    end
    in_valid   = 1'b1;
    in_buttons = buttons;
    do @(posedge clk); while (!in_ready);
    frame_chk.note_step(buttons);
    @(negedge clk);
  endtask

  task automatic write_hold(input logic [CFG_IDX_W-1:0] idx, input logic [HOLD_W-1:0] val);
    cfg_valid = 1'b1;
    cfg_index = idx;
    cfg_data  = val;
    do @(posedge clk); while (!cfg_ready);
    frame_chk.write_hold(idx, val);
    @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  task automatic apply_holds(input logic [HOLD_W-1:0] cylon, input logic [HOLD_W-1:0] counter,
                             input logic [HOLD_W-1:0] shuffle, input logic [HOLD_W-1:0] fast,
                             input logic [HOLD_W-1:0] off, input logic [CFG_IDX_W-1:0] spare);
    write_hold(REG_CYLON_HOLD, cylon);
    write_hold(REG_COUNTER_HOLD, counter);
    write_hold(REG_SHUFFLE_HOLD, shuffle);
    write_hold(REG_SHUFFLE_FAST_HOLD, fast);
    write_hold(REG_OFF_HOLD, off);
    // a stray write that must leave every hold alone
    write_hold(spare, HOLD_W'($urandom_range(65535)));
  endtask

  // Drop valid and wait for every predicted frame, then let the pipeline settle.
  task automatic drain();
    in_valid = 1'b0;
    while (frame_chk.pending() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  function automatic logic [BTN_W-1:0] pick_press();
    case ($urandom_range(9)) inside
      [0:2]:   return MODE_CYLON;
      [3:5]:   return MODE_COUNTER;
      [6:8]:   return MODE_SHUFFLE;
      default: return BTN_W'($urandom_range(1, 15));
    endcase
  endfunction

  // Mostly well-formed runs: a press followed by plain steps, with some stray presses.
  task automatic run_patterns(input int unsigned n_items);
    int unsigned      sent;
    int unsigned      run_len;
    logic [BTN_W-1:0] code;
    sent = 0;
    while (sent < n_items) begin
      send_step(pick_press());
      sent++;
      run_len = ($urandom_range(9) == 0) ? $urandom_range(40, 120) : $urandom_range(1, 40);
      repeat (run_len) begin
        code = ($urandom_range(99) < 85) ? BTN_NONE : BTN_W'($urandom_range(1, 15));
        send_step(code);
        sent++;
      end
    end
  endtask

  initial begin
    // hold reset, then release it on a falling edge
    repeat (5) @(negedge clk);
    rst_n = 1'b1;

    // Directed: reset holds, off display, odd code and ignored overlap, each pattern,
    // a full shuffle pass through the fast frame and its restart, then odd codes again.
    send_step(BTN_NONE);
    send_step(4'd1);
    send_step(4'd1);
    send_step(MODE_CYLON);
    send_step(BTN_NONE);
    send_step(MODE_COUNTER);
    send_step(BTN_NONE);
    send_step(MODE_SHUFFLE);
    repeat (15) send_step(BTN_NONE);
    send_step(4'd5);
    send_step(4'd15);
    drain();

    for (int ph = 0; ph < 4; ph++) begin
      case (ph)
        0: begin
          send_idle_pct  = 0;
          recv_stall_pct = 0;
          apply_holds('0, '0, '0, '0, '0, REG_SPARE_7);
        end
        1: begin
          send_idle_pct  = 84;
          recv_stall_pct = 0;
          apply_holds('1, '1, '1, '1, '1, REG_SPARE_5);
        end
        2: begin
          send_idle_pct  = 0;
          recv_stall_pct = 84;
          apply_holds(HOLD_W'($urandom_range(65535)), HOLD_W'($urandom_range(65535)),
                      HOLD_W'($urandom_range(65535)), HOLD_W'($urandom_range(65535)),
                      HOLD_W'($urandom_range(65535)), REG_SPARE_6);
        end
        default: begin
          send_idle_pct  = 21;
          recv_stall_pct = 21;
          apply_holds(HOLD_W'($urandom_range(255)), HOLD_W'($urandom_range(65535)),
                      HOLD_W'($urandom_range(1, 65534)), HOLD_W'($urandom_range(65535)),
                      HOLD_W'($urandom_range(255)), REG_SPARE_7);
        end
      endcase
      if (ph == 0) begin
        // switch through cylon into the counter and run it past the wrap at 0x3FF
        send_step(MODE_CYLON);
        send_step(MODE_COUNTER);
        repeat (int'(COUNT_WRAP) + 8) send_step(BTN_NONE);
        run_patterns(40);
      end else begin
        run_patterns(140);
      end
      drain();
    end

    if (frame_chk.failures == 0 && frame_chk.pending() == 0)
      $display("PASSED: all results match");
    else
      $display("FAILED: results differ");
    $finish;
  end

endmodule
